// ----- src/brg_pkg.sv -----
// Shared constants, types and the arctangent step table for the bearing block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package brg_pkg;

   // defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF     = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STAGES_DEF   = 16;

   // fixed-point formats
   localparam int GUARD_BITS = 24;   // left shift applied to |dx|, |dy|
   localparam int ACC_FRAC   = 24;   // fraction bits of the degree accumulator
   localparam int TABLE_LEN  = 32;   // rotations available in the step table
   localparam int Z_W        = 33;   // accumulator width, covers about +-256 deg

   // 90 degrees in accumulator format
   localparam logic [Z_W-1:0] NINETY_ACC = Z_W'(64'd90 << ACC_FRAC);

   // sign/zero flags of dx and dy, carried alongside each beat
   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_neg;
   } brg_quad_type;

   // round(atan(2^-i) * 180/pi * 2^24)
   function automatic logic signed [Z_W-1:0] atan_deg_step(input int idx);
      logic signed [Z_W-1:0] step;
      unique case (idx)
         0:  step = 33'sd754974720;
         1:  step = 33'sd445687602;
         2:  step = 33'sd235489088;
         3:  step = 33'sd119537938;
         4:  step = 33'sd60000934;
         5:  step = 33'sd30029717;
         6:  step = 33'sd15018523;
         7:  step = 33'sd7509720;
         8:  step = 33'sd3754917;
         9:  step = 33'sd1877466;
         10: step = 33'sd938734;
         11: step = 33'sd469367;
         12: step = 33'sd234683;
         13: step = 33'sd117342;
         14: step = 33'sd58671;
         15: step = 33'sd29335;
         16: step = 33'sd14668;
         17: step = 33'sd7334;
         18: step = 33'sd3667;
         19: step = 33'sd1833;
         20: step = 33'sd917;
         21: step = 33'sd458;
         22: step = 33'sd229;
         23: step = 33'sd115;
         24: step = 33'sd57;
         25: step = 33'sd29;
         26: step = 33'sd14;
         27: step = 33'sd7;
         28: step = 33'sd4;
         29: step = 33'sd2;
         30: step = 33'sd1;
         default: step = '0;
      endcase
      return step;
   endfunction

endpackage

// ----- src/brg_prep.sv -----
// Front stage: forms dx/dy, takes magnitudes, scales them into the CORDIC format.
// Depends on brg_pkg.
`timescale 1ns / 1ps

module brg_prep #(
   parameter int COORD_WIDTH = 16,
   parameter int DATA_W      = 44
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             beat_valid,
   input  logic signed [COORD_WIDTH-1:0]    origin_x,
   input  logic signed [COORD_WIDTH-1:0]    origin_y,
   input  logic signed [COORD_WIDTH-1:0]    target_x,
   input  logic signed [COORD_WIDTH-1:0]    target_y,
   output logic                             out_valid,
   output logic signed [DATA_W-1:0]         out_x,
   output logic signed [DATA_W-1:0]         out_y,
   output brg_pkg::brg_quad_type            out_quad
);
   import brg_pkg::*;

   logic signed [COORD_WIDTH:0] dx, dy;
   logic        [COORD_WIDTH:0] ax, ay;

   logic                     valid_ff;
   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in;
   brg_quad_type             quad_ff, quad_in;

   // one bit wider than the inputs: no wrap
   assign dx = (COORD_WIDTH+1)'(origin_x) - (COORD_WIDTH+1)'(target_x);
   assign dy = (COORD_WIDTH+1)'(origin_y) - (COORD_WIDTH+1)'(target_y);

   always_comb begin
      ax = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
      ay = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
      x_in = $signed(DATA_W'(ax) << GUARD_BITS);
      y_in = $signed(DATA_W'(ay) << GUARD_BITS);
      quad_in.dx_zero = (dx == '0);
      quad_in.dx_neg  = dx[COORD_WIDTH];
      quad_in.dy_neg  = dy[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      quad_ff <= quad_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_quad  = quad_ff;

endmodule

// ----- src/brg_cordic_stage.sv -----
// One vectoring CORDIC rotation, registered. Angle accumulated in degrees.
// Depends on brg_pkg (step table, flag struct).
`timescale 1ns / 1ps

module brg_cordic_stage #(
   parameter int DATA_W    = 44,
   parameter int STAGE_IDX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              prev_valid,
   input  logic signed [DATA_W-1:0]          prev_x,
   input  logic signed [DATA_W-1:0]          prev_y,
   input  logic signed [brg_pkg::Z_W-1:0]    prev_z,
   input  brg_pkg::brg_quad_type             prev_quad,
   output logic                              out_valid,
   output logic signed [DATA_W-1:0]          out_x,
   output logic signed [DATA_W-1:0]          out_y,
   output logic signed [brg_pkg::Z_W-1:0]    out_z,
   output brg_pkg::brg_quad_type             out_quad
);
   import brg_pkg::*;

   localparam logic signed [Z_W-1:0] STEP = atan_deg_step(STAGE_IDX);

   logic signed [DATA_W-1:0] xs, ys;
   logic                     valid_ff;
   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   brg_quad_type             quad_ff;

   // arithmetic shift = floor division by 2^i
   assign xs = prev_x >>> STAGE_IDX;
   assign ys = prev_y >>> STAGE_IDX;

   always_comb begin
      priority if (prev_y[DATA_W-1]) begin
         x_in = prev_x - ys;
         y_in = prev_y + xs;
         z_in = prev_z - STEP;
      end else if (prev_y != '0) begin
         x_in = prev_x + ys;
         y_in = prev_y - xs;
         z_in = prev_z + STEP;
      end else begin
         // zero y: pass through
         x_in = prev_x;
         y_in = prev_y;
         z_in = prev_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= prev_quad;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_quad  = quad_ff;

endmodule

// ----- src/brg_post.sv -----
// Back end: clamp and round the CORDIC angle, then place it by quadrant.
// Two register stages. Depends on brg_pkg.
`timescale 1ns / 1ps

module brg_post #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 prev_valid,
   input  logic signed [brg_pkg::Z_W-1:0]       prev_z,
   input  brg_pkg::brg_quad_type                prev_quad,
   output logic                                 out_valid,
   output logic signed [ANGLE_FRAC_BITS+8:0]    out_angle
);
   import brg_pkg::*;

   localparam int OUT_W = ANGLE_FRAC_BITS + 9;
   localparam int A_W   = ANGLE_FRAC_BITS + 7;   // 0..90 deg
   localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [Z_W-1:0]   ROUND_HALF = Z_W'(1) << (SH - 1);
   localparam logic [OUT_W-1:0] NINETY_OUT = OUT_W'(90) << ANGLE_FRAC_BITS;

   // stage A: clamp to [0, 90] and round half up
   logic [Z_W-1:0] z_clamp, z_rnd;
   logic           a_valid_ff;
   logic [A_W-1:0] a_ff, a_in;
   brg_quad_type   a_quad_ff;

   always_comb begin
      priority if (prev_z[Z_W-1]) begin
         z_clamp = '0;
      end else if ($unsigned(prev_z) > NINETY_ACC) begin
         z_clamp = NINETY_ACC;
      end else begin
         z_clamp = $unsigned(prev_z);
      end
      z_rnd = z_clamp + ROUND_HALF;
      a_in  = z_rnd[SH +: A_W];
   end

   // stage B: quadrant placement
   logic [OUT_W-1:0] a_ext;
   logic             b_valid_ff;
   logic [OUT_W-1:0] b_angle_ff, b_angle_in;

   always_comb begin
      a_ext = OUT_W'(a_ff);
      priority if (a_quad_ff.dx_zero) begin
         b_angle_in = '0;
      end else if (!a_quad_ff.dx_neg) begin
         b_angle_in = a_quad_ff.dy_neg ? (-(a_ext + NINETY_OUT)) : (a_ext - NINETY_OUT);
      end else begin
         b_angle_in = a_quad_ff.dy_neg ? (a_ext + NINETY_OUT) : (NINETY_OUT - a_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= prev_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      a_quad_ff  <= prev_quad;
      b_angle_ff <= b_angle_in;
   end

   assign out_valid = b_valid_ff;
   assign out_angle = $signed(b_angle_ff);

endmodule

// ----- src/bearing_angle_degrees_top.sv -----
// Bearing from an origin point to a target point, degrees with fraction bits.
// Instantiates brg_prep, brg_cordic_stage (one per rotation), brg_post; uses brg_pkg.
`timescale 1ns / 1ps
//
//   channel    ports                                   handshake
//   ---------  --------------------------------------  -------------------------------
//   request    req_origin_x/y, req_target_x/y          beat taken when start && !busy
//   response   rsp_angle_deg                           rsp_valid strobe, one cycle
//
// Cycles: a beat is taken every cycle; busy stays low. Its result is registered through
// the front stage, one stage per CORDIC rotation, the clamp/round stage and the quadrant
// stage, in that order.
// Rotations beyond 32 are not built; the step table ends there.
// Reset (synchronous) clears only the valid bits; beats in flight are dropped.
// No stalls: the receiver always takes the strobe, so the pipe never holds.
//
// Result: dx = origin_x - target_x, dy = origin_y - target_y,
// a = atan(|dy|/|dx|) in degrees, then
//   dx > 0 : dy < 0 ? -(a + 90) : a - 90
//   dx < 0 : dy < 0 ?   a + 90  : 90 - a
//   dx == 0: 0

module bearing_angle_degrees_top #(
   parameter int COORD_WIDTH     = brg_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = brg_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = brg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_WIDTH-1:0]      req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]      req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]      req_target_x,
   input  logic signed [COORD_WIDTH-1:0]      req_target_y,
   output logic                               rsp_valid,
   output logic signed [ANGLE_FRAC_BITS+8:0]  rsp_angle_deg
);
   import brg_pkg::*;

   // |dx| << GUARD_BITS, gain ~1.65 and sign headroom
   localparam int DATA_W   = COORD_WIDTH + GUARD_BITS + 4;
   localparam int NUM_ITER = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   // pipe taps, index k = input of rotation k
   logic                     pipe_valid [0:NUM_ITER];
   logic signed [DATA_W-1:0] pipe_x     [0:NUM_ITER];
   logic signed [DATA_W-1:0] pipe_y     [0:NUM_ITER];
   logic signed [Z_W-1:0]    pipe_z     [0:NUM_ITER];
   brg_quad_type             pipe_quad  [0:NUM_ITER];

   // the pipe always advances
   assign busy = 1'b0;

   brg_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_W      (DATA_W)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (start && !busy),
      .origin_x   (req_origin_x),
      .origin_y   (req_origin_y),
      .target_x   (req_target_x),
      .target_y   (req_target_y),
      .out_valid  (pipe_valid[0]),
      .out_x      (pipe_x[0]),
      .out_y      (pipe_y[0]),
      .out_quad   (pipe_quad[0])
   );

   // accumulator starts at zero degrees
   assign pipe_z[0] = '0;

   for (genvar k = 0; k < NUM_ITER; k++) begin : g_rot
      brg_cordic_stage #(
         .DATA_W    (DATA_W),
         .STAGE_IDX (k)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (pipe_valid[k]),
         .prev_x     (pipe_x[k]),
         .prev_y     (pipe_y[k]),
         .prev_z     (pipe_z[k]),
         .prev_quad  (pipe_quad[k]),
         .out_valid  (pipe_valid[k+1]),
         .out_x      (pipe_x[k+1]),
         .out_y      (pipe_y[k+1]),
         .out_z      (pipe_z[k+1]),
         .out_quad   (pipe_quad[k+1])
      );
   end

   brg_post #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .prev_valid (pipe_valid[NUM_ITER]),
      .prev_z     (pipe_z[NUM_ITER]),
      .prev_quad  (pipe_quad[NUM_ITER]),
      .out_valid  (rsp_valid),
      .out_angle  (rsp_angle_deg)
   );

endmodule

// ----- src/brg_checker.sv -----
// Port-level checks for bearing_angle_degrees_top, attached by bind.
// Depends on brg_pkg.
`timescale 1ns / 1ps

module brg_checker #(
   parameter int COORD_WIDTH     = brg_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = brg_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = brg_pkg::CORDIC_STAGES_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic signed [COORD_WIDTH-1:0]      req_origin_x,
   input logic signed [COORD_WIDTH-1:0]      req_target_x,
   input logic                               rsp_valid,
   input logic signed [ANGLE_FRAC_BITS+8:0]  rsp_angle_deg
);
   import brg_pkg::*;

   localparam int NUM_ITER = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int LAT      = NUM_ITER + 3;
   localparam logic signed [ANGLE_FRAC_BITS+8:0] HALF_TURN =
      (ANGLE_FRAC_BITS+9)'(180) << ANGLE_FRAC_BITS;

   logic beat_taken;
   assign beat_taken = start && !busy;

   // every accepted beat yields a strobe after the fixed latency
   a_beat_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      beat_taken |-> ##LAT rsp_valid)
      else $error("accepted beat produced no response");

   // no strobe without a beat behind it
   a_rsp_has_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(beat_taken, LAT))
      else $error("response without an accepted beat");

   // vertical line gives zero
   a_vertical_zero: assert property (@(posedge clock) disable iff (reset)
      (beat_taken && (req_origin_x == req_target_x)) |-> ##LAT (rsp_angle_deg == '0))
      else $error("dx == 0 did not give zero");

   // bearing stays within half a turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_angle_deg <= HALF_TURN) && (rsp_angle_deg >= -HALF_TURN)))
      else $error("angle out of range");

endmodule

bind bearing_angle_degrees_top brg_checker #(
   .COORD_WIDTH     (COORD_WIDTH),
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
   .CORDIC_STAGES   (CORDIC_STAGES)
) u_brg_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_origin_x  (req_origin_x),
   .req_target_x  (req_target_x),
   .rsp_valid     (rsp_valid),
   .rsp_angle_deg (rsp_angle_deg)
);

// ----- tb/testbench.sv -----
// Self-checking bench for bearing_angle_degrees_top: point pairs in, bearing out.
// Depends on brg_pkg (format constants) and the RTL top; the expected angle comes from
// an independent CORDIC arctangent written here.
`timescale 1ns / 1ps

module testbench;
   import brg_pkg::*;

   localparam int CW      = COORD_WIDTH_DEF;
   localparam int AFB     = ANGLE_FRAC_BITS_DEF;
   localparam int STAGES  = CORDIC_STAGES_DEF;
   localparam int AW      = AFB + 9;          // width of the angle port
   localparam int LATENCY = STAGES + 3;       // front, rotation, clamp/round and quadrant stages
   localparam int CYCLE_LIMIT = 60000;        // far beyond the slowest legal run
   localparam int N_RANDOM    = 450;

   // Rotation angles in degrees, 24 fraction bits: round(atan(2^-i) * 180/pi * 2^24).
   localparam longint ATAN_STEP_DEG [0:31] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934, 30029717, 15018523, 7509720,
      3754917, 1877466, 938734, 469367,
      234683, 117342, 58671, 29335,
      14668, 7334, 3667, 1833,
      917, 458, 229, 115,
      57, 29, 14, 7,
      4, 2, 1, 0
   };

   typedef struct {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic signed [CW-1:0] tx;
      logic signed [CW-1:0] ty;
      bit                   drain_first;   // hold start until every bearing is back
   } point_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic signed [CW-1:0]   req_origin_x = '0;
   logic signed [CW-1:0]   req_origin_y = '0;
   logic signed [CW-1:0]   req_target_x = '0;
   logic signed [CW-1:0]   req_target_y = '0;
   logic                   rsp_valid;
   logic signed [AW-1:0]   rsp_angle_deg;

   point_pair_type         pending_pairs[$];
   logic signed [AW-1:0]   expected_angles[$];
   int                     pairs_sent    = 0;
   int                     angles_seen   = 0;
   int                     mismatch_count = 0;
   int                     cycle_count   = 0;
   int                     stall_cycles  = 0;

   always #5 clock = ~clock;

   bearing_angle_degrees_top #(
      .COORD_WIDTH     (CW),
      .ANGLE_FRAC_BITS (AFB),
      .CORDIC_STAGES   (STAGES)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_origin_x  (req_origin_x),
      .req_origin_y  (req_origin_y),
      .req_target_x  (req_target_x),
      .req_target_y  (req_target_y),
      .rsp_valid     (rsp_valid),
      .rsp_angle_deg (rsp_angle_deg)
   );

   // Bearing from origin to target, degrees with AFB fraction bits.
   // Vectoring CORDIC on |dx|, |dy| with 24 guard bits; shifts floor (>>> on longint).
   function automatic logic signed [AW-1:0] bearing_of(
         input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
         input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty);
      longint dx, dy, x, y, xs, ys, z, a, ninety, angle;
      int     n_rot;
      dx = longint'(ox) - longint'(tx);     // full precision, no wrap
      dy = longint'(oy) - longint'(ty);
      if (dx == 0)
         return '0;                         // vertical line, any dy
      x = (dx < 0 ? -dx : dx) <<< GUARD_BITS;
      y = (dy < 0 ? -dy : dy) <<< GUARD_BITS;
      z = 0;
      n_rot = (STAGES > 32) ? 32 : STAGES;
      for (int i = 0; i < n_rot; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP_DEG[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP_DEG[i];
         end
      end
      if (z < 0)
         z = 0;
      if (z > (longint'(90) <<< ACC_FRAC))
         z = longint'(90) <<< ACC_FRAC;
      // round half up to AFB fraction bits
      a = (z + (longint'(1) <<< (ACC_FRAC - AFB - 1))) >>> (ACC_FRAC - AFB);
      ninety = longint'(90) <<< AFB;
      if (dx > 0)
         angle = (dy < 0) ? -(a + ninety) : (a - ninety);
      else
         angle = (dy < 0) ? (a + ninety) : (ninety - a);
      return AW'(angle);
   endfunction

   task automatic add_pair(input int ox, input int oy, input int tx, input int ty,
                           input bit drain = 1'b0);
      point_pair_type p;
      p.ox = CW'(ox);
      p.oy = CW'(oy);
      p.tx = CW'(tx);
      p.ty = CW'(ty);
      p.drain_first = drain;
      pending_pairs.push_back(p);
   endtask

   function automatic int edge_coord();
      case ($urandom_range(4))
         0: return -32768;
         1: return -1;
         2: return 0;
         3: return 1;
         default: return 32767;
      endcase
   endfunction

   // Driver. Start stays up across back-to-back beats; the predicted bearing is
   // queued on the edge that takes the beat (start && !busy, pre-edge values).
   always @(posedge clock) begin
      point_pair_type nxt;
      bit             idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_angles.push_back(bearing_of(req_origin_x, req_origin_y,
                                                 req_target_x, req_target_y));
            pairs_sent++;
         end
         // ~34% idle cycles, except for a stretch of back-to-back beats
         idle = (pairs_sent >= 120 && pairs_sent < 220) ? 1'b0
                                                          : ($urandom_range(99) < 34);
         if (start && busy) begin
            // beat not taken yet: hold everything
         end else if (pending_pairs.size() != 0 && !idle &&
                      !(pending_pairs[0].drain_first && expected_angles.size() != 0)) begin
            nxt = pending_pairs.pop_front();
            start        <= 1'b1;
            req_origin_x <= nxt.ox;
            req_origin_y <= nxt.oy;
            req_target_x <= nxt.tx;
            req_target_y <= nxt.ty;
         end else begin
            start <= 1'b0;
            if (pending_pairs.size() != 0)
               stall_cycles++;
         end
      end
   end

   // Monitor. The strobe lasts one cycle and cannot be held off, so every
   // rsp_valid seen at an edge is a result beat.
   always @(posedge clock) begin
      logic signed [AW-1:0] want;
      if (!reset && rsp_valid) begin
         angles_seen++;
         if (expected_angles.size() == 0) begin
            $error("unexpected result beat: angle_deg=%0d", rsp_angle_deg);
            mismatch_count++;
         end else begin
            want = expected_angles.pop_front();
            if (rsp_angle_deg !== want) begin
               $error("angle_deg mismatch: expected %0d, actual %0d", want, rsp_angle_deg);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[bearing_angle_degrees_top] ERROR");
         $finish;
      end
   end

   initial begin
      int r, ox, oy, d, ex, ey;

      // Directed: equal points, vertical and horizontal lines, diagonals,
      // full-range deltas in every quadrant.
      add_pair(0, 0, 0, 0);                       // equal points at zero
      add_pair(-32768, -32768, -32768, -32768);   // equal points at the corner
      add_pair(32767, 32767, 32767, 32767);
      add_pair(5, 32767, 5, -32768);              // vertical, dy > 0
      add_pair(-7, -32768, -7, 32767);            // vertical, dy < 0
      add_pair(32767, 9, -32768, 9);              // horizontal, dx > 0
      add_pair(-32768, -3, 32767, -3);            // horizontal, dx < 0
      add_pair(1, 1, 0, 0);                       // 45 deg diagonals, all quadrants
      add_pair(1, -1, 0, 0);
      add_pair(-1, 1, 0, 0);
      add_pair(-1, -1, 0, 0);
      add_pair(32767, 32767, -32768, -32768);     // largest |dx| = |dy|
      add_pair(32767, -32768, -32768, 32767);
      add_pair(-32768, 32767, 32767, -32768);
      add_pair(-32768, -32768, 32767, 32767);
      add_pair(1, 32767, 0, -32768);              // nearly vertical
      add_pair(-1, -32768, 0, 32767);
      add_pair(32767, 1, -32768, 0);              // nearly horizontal
      add_pair(-32768, 0, 32767, 1);
      add_pair(3, 4, 0, 0);
      add_pair(-12, 5, 0, 0);

      // Random: mostly structured deltas, plus raw noise on all bits.
      for (int k = 0; k < N_RANDOM; k++) begin
         r  = $urandom_range(99);
         ox = $signed(CW'($urandom));
         oy = $signed(CW'($urandom));
         if (r < 40) begin
            add_pair(ox, oy, $signed(CW'($urandom)), $signed(CW'($urandom)),
                     k == 150 || k == 330);
         end else if (r < 65) begin
            add_pair(ox, oy, ox + $urandom_range(600) - 300, oy + $urandom_range(600) - 300);
         end else if (r < 75) begin
            add_pair(ox, oy, ox, $signed(CW'($urandom)));
         end else if (r < 85) begin
            add_pair(ox, oy, $signed(CW'($urandom)), oy);
         end else if (r < 92) begin
            add_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord());
         end else begin
            d  = $urandom_range(32767);
            ex = $urandom_range(1) ? d : -d;
            ey = $urandom_range(1) ? d : -d;
            add_pair(ox, oy, ox + ex, oy + ey);
         end
         // make sure the drain pause happens whichever branch ran
         if (k == 150 || k == 330)
            pending_pairs[pending_pairs.size()-1].drain_first = 1'b1;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all beats taken, all bearings back, then let the pipe run dry
      while (pending_pairs.size() != 0 || start || expected_angles.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("sent %0d point pairs, checked %0d bearings, %0d idle cycles, %0d mismatches",
               pairs_sent, angles_seen, stall_cycles, mismatch_count);
      $display("covered: equal points, vertical/horizontal lines, diagonals, extremes, drains");
      if (mismatch_count == 0 && expected_angles.size() == 0)
         $display("[bearing_angle_degrees_top] OK");
      else
         $display("[bearing_angle_degrees_top] ERROR");
      $finish;
   end

endmodule
